// ===== rtl/core/wamg_pkg.sv =====
// Shared types and constants for the windowed average monotonic gauge.
// No dependencies; imported by the gauge core top level.
package wamg_pkg;

    // Default sizing handed to the top-level parameters
    localparam int DEF_SAMPLE_BITS = 10;
    localparam int DEF_MAX_WINDOW  = 4096;

    // Configuration register file
    localparam int          LIMIT_W     = 12;
    localparam int          PADDR_W     = 3;
    localparam int          PDATA_W     = 32;
    localparam int          REG_IDX_W   = PADDR_W - 2;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET      = 12'd2400;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LIMIT = 1'b0;

    // Request kinds carried on the mode field
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/core/windowed_average_monotonic_gauge_core.sv =====
// Windowed average gauge with monotonic hold: sequencer, state and APB registers.
// Depends on wamg_pkg and wamg_div.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+----------------------------------
//  request   | in        | in_valid / in_ready     | mode, adc_sample, charging
//  result    | out       | out_valid / out_ready   | level_value, level_valid, window_closed
//  config    | in        | psel/penable/pwrite     | paddr, pwdata, prdata (pready tied high)
//
// No-average request: accepted straight into ST_DONE, which loads the result register.
// Window close or first level: ST_DIV waits on the bit-serial divider, then ST_DONE
// loads the result register.
// in_ready is high only while the sequencer is idle.
// Reset clears all state and loads the window limit with 2400.
// A stalled result holds in the output register; the next one waits in ST_DONE.
module windowed_average_monotonic_gauge_core
    import wamg_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // request channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   mode,
    input  logic [SAMPLE_BITS-1:0] adc_sample,
    input  logic                   charging,
    // result channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] level_value,
    output logic                   level_valid,
    output logic                   window_closed,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    localparam int CW    = $clog2(MAX_WINDOW) + 1;
    localparam int TW    = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int CMP_W = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam logic [CMP_W-1:0] LIMIT_CAP = CMP_W'(MAX_WINDOW - 1);

    state_t                 state_reg, state_next;
    logic [LIMIT_W-1:0]     limit_reg, limit_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [SAMPLE_BITS-1:0] held_level_reg, held_level_next;
    logic                   held_valid_reg, held_valid_next;
    logic                   op_close_reg, op_close_next;
    logic                   op_read_reg, op_read_next;
    logic                   op_chg_reg, op_chg_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_level_reg, out_level_next;
    logic                   out_lvalid_reg, out_lvalid_next;
    logic                   out_closed_reg, out_closed_next;

    logic                   div_start;
    logic [TW-1:0]          div_dvd;
    logic [CW-1:0]          div_dvr;
    logic                   div_done;
    logic [TW-1:0]          div_quo;

    logic [CMP_W-1:0]       limit_wide;
    logic [CW-1:0]          limit_eff;
    logic [TW-1:0]          total_sum;
    logic [SAMPLE_BITS-1:0] avg;
    logic                   cfg_wr;
    logic [REG_IDX_W-1:0]   reg_idx;

    wamg_div #(
        .DVD_W (TW),
        .DVR_W (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvr),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Effective limit, capped to the deepest window the counter supports
    always_comb
    begin
        limit_wide = CMP_W'(limit_reg);
        if (limit_wide > LIMIT_CAP)
        begin
            limit_wide = LIMIT_CAP;
        end
        limit_eff = limit_wide[CW-1:0];
    end

    assign total_sum = total_reg + TW'(adc_sample);

    // Average saturated to the sample range
    assign avg = (|div_quo[TW-1:SAMPLE_BITS]) ? '1 : div_quo[SAMPLE_BITS-1:0];

    // APB access
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_idx == REG_WINDOW_LIMIT) ? PDATA_W'(limit_reg) : '0;

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next      = state_reg;
        limit_next      = limit_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        held_level_next = held_level_reg;
        held_valid_next = held_valid_reg;
        op_close_next   = op_close_reg;
        op_read_next    = op_read_reg;
        op_chg_next     = op_chg_reg;
        out_valid_next  = out_valid_reg;
        out_level_next  = out_level_reg;
        out_lvalid_next = out_lvalid_reg;
        out_closed_next = out_closed_reg;
        div_start       = 1'b0;
        div_dvd         = total_sum;
        div_dvr         = count_reg;
        in_ready        = 1'b0;

        if (cfg_wr && (reg_idx == REG_WINDOW_LIMIT))
        begin
            limit_next = pwdata[LIMIT_W-1:0];
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_close_next = 1'b0;
                    op_read_next  = 1'b0;
                    op_chg_next   = charging;
                    state_next    = ST_DONE;
                    if (mode == MODE_SAMPLE)
                    begin
                        if (count_reg >= limit_eff)
                        begin
                            // window closes: average over count+1 samples
                            op_close_next = 1'b1;
                            div_start     = 1'b1;
                            div_dvd       = total_sum;
                            div_dvr       = count_reg + CW'(1);
                            count_next    = '0;
                            total_next    = '0;
                            state_next    = ST_DIV;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                            total_next = total_sum;
                        end
                    end
                    else if (!held_valid_reg && (count_reg != '0))
                    begin
                        // first read with pending samples: partial average
                        op_read_next = 1'b1;
                        div_start    = 1'b1;
                        div_dvd      = total_reg;
                        div_dvr      = count_reg;
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (op_read_reg)
                    begin
                        held_level_next = avg;
                        held_valid_next = 1'b1;
                    end
                    else if (op_chg_reg)
                    begin
                        // charging: level only rises, never created
                        if (held_valid_reg && (avg > held_level_reg))
                        begin
                            held_level_next = avg;
                        end
                    end
                    else if (!held_valid_reg || (avg < held_level_reg))
                    begin
                        // discharging: level only falls, or is created if none is held
                        held_level_next = avg;
                        held_valid_next = 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_level_next  = held_valid_reg ? held_level_reg : '0;
                    out_lvalid_next = held_valid_reg;
                    out_closed_next = op_close_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            limit_reg      <= LIMIT_RESET;
            count_reg      <= '0;
            total_reg      <= '0;
            held_level_reg <= '0;
            held_valid_reg <= 1'b0;
            op_close_reg   <= 1'b0;
            op_read_reg    <= 1'b0;
            op_chg_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_level_reg  <= '0;
            out_lvalid_reg <= 1'b0;
            out_closed_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            limit_reg      <= limit_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            held_level_reg <= held_level_next;
            held_valid_reg <= held_valid_next;
            op_close_reg   <= op_close_next;
            op_read_reg    <= op_read_next;
            op_chg_reg     <= op_chg_next;
            out_valid_reg  <= out_valid_next;
            out_level_reg  <= out_level_next;
            out_lvalid_reg <= out_lvalid_next;
            out_closed_reg <= out_closed_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign level_value   = out_level_reg;
    assign level_valid   = out_lvalid_reg;
    assign window_closed = out_closed_reg;

    // Once a level exists it never goes away
    a_held_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |=> held_valid_reg)
        else $error("held level lost its valid flag");

    // Divider is only launched from idle on an accepted request
    a_div_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == ST_IDLE) && in_valid)
        else $error("divider started outside an accepted request");

    // Sample count never passes the deepest window
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= LIMIT_CAP)
        else $error("sample count beyond window capacity");

    // A divide finishing outside ST_DIV would drop an average
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished while sequencer not waiting");

endmodule

// ===== rtl/core/wamg_div.sv =====
// Restoring divider, one quotient bit per cycle, one shared subtractor.
// Depends on nothing outside this file (the package is not needed here).
module wamg_div #(
    parameter int DVD_W = 22,
    parameter int DVR_W = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVR_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVR_W-1:0] rem_reg;
    logic [DVR_W-1:0] dvr_reg;

    logic [DVR_W:0]   trial;
    logic [DVR_W:0]   diff;
    logic             fits;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        diff  = trial - {1'b0, dvr_reg};
        fits  = (trial >= {1'b0, dvr_reg});
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == STEP_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: quotient bits shift in where the dividend shifts out
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
